// ===== src/uer_pkg.sv =====
// uer_pkg: shared types and constants for the ultrasonic echo ranger.
// No dependencies.
`timescale 1ns / 1ps

package uer_pkg;

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_TRIG,
        PH_WAIT,
        PH_MEAS
    } t_phase;

    typedef enum logic [1:0] {
        ST_OK,
        ST_NO_RISE,
        ST_NO_FALL,
        ST_RANGE
    } t_status;

    typedef enum logic [1:0] {
        CFG_TIMEOUT,
        CFG_TRIGGER,
        CFG_MIN_CM,
        CFG_MAX_CM
    } t_cfg_idx;

    localparam int US_PER_CM = 58;
    localparam int CNT_W     = 17;
    localparam int WIDTH_W   = 16;
    localparam int DIST_W    = 14;
    localparam int CM_W      = 10;
    localparam int TRIG_W    = 8;
    localparam int CFG_W     = 16;
    localparam int IN_W      = 8;
    localparam int OUT_W     = 24;

    localparam logic [DIST_W-1:0]  DIST_MAX     = '1;
    localparam logic [WIDTH_W-1:0] TIMEOUT_RST  = 16'd25000;
    localparam logic [TRIG_W-1:0]  TRIGGER_RST  = 8'd10;
    localparam logic [CM_W-1:0]    MIN_CM_RST   = 10'd2;
    localparam logic [CM_W-1:0]    MAX_CM_RST   = 10'd400;

    typedef struct packed {
        logic [WIDTH_W-1:0] timeout;
        logic [TRIG_W-1:0]  trigger;
        logic [CM_W-1:0]    min_cm;
        logic [CM_W-1:0]    max_cm;
    } t_cfg;

    // one item after the sequencer step
    typedef struct packed {
        logic               trig;
        logic               done;
        t_status            status;
        logic               meas_end;
        logic [WIDTH_W-1:0] width;
    } t_step;

    typedef struct packed {
        logic              trig;
        logic              done;
        t_status           status;
        logic [DIST_W-1:0] dist_q4;
    } t_res;

endpackage

// ===== src/uer_ctrl.sv =====
// uer_ctrl: measurement sequencer (idle, trigger, rise wait, pulse count).
// Registers one step record per item. Depends on uer_pkg.
`timescale 1ns / 1ps

module uer_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  uer_pkg::t_cfg i_cfg,
    input  logic          i_acc,
    input  logic          i_start,
    input  logic          i_echo,
    input  logic          i_take,
    output logic          o_ready,
    output logic          o_s1_vld,
    output uer_pkg::t_step o_s1
);
    import uer_pkg::*;

    t_phase             r_phase, n_phase;
    logic [CNT_W-1:0]   r_cnt, n_cnt;
    logic               r_s1_vld;
    t_step              r_s1, n_step;
    logic [TRIG_W-1:0]  trig_len;
    logic [CNT_W-1:0]   c_inc;
    logic               len_hit, over;

    assign trig_len = (i_cfg.trigger == '0) ? TRIG_W'(1) : i_cfg.trigger;
    assign c_inc    = r_cnt + CNT_W'(1);
    assign len_hit  = c_inc >= CNT_W'(trig_len);
    assign over     = c_inc > CNT_W'(i_cfg.timeout);

    always_comb begin
        n_phase = r_phase;
        n_cnt   = r_cnt;
        if (i_acc) begin
            case (r_phase)
                PH_IDLE: begin
                    if (i_start) begin
                        if (trig_len == TRIG_W'(1)) begin
                            n_phase = PH_WAIT;
                            n_cnt   = '0;
                        end else begin
                            n_phase = PH_TRIG;
                            n_cnt   = CNT_W'(1);
                        end
                    end
                end
                PH_TRIG: begin
                    if (len_hit) begin
                        n_phase = PH_WAIT;
                        n_cnt   = '0;
                    end else begin
                        n_cnt = c_inc;
                    end
                end
                PH_WAIT: begin
                    if (i_echo) begin
                        n_phase = PH_MEAS;
                        n_cnt   = CNT_W'(1);
                    end else if (over) begin
                        n_phase = PH_IDLE;
                        n_cnt   = '0;
                    end else begin
                        n_cnt = c_inc;
                    end
                end
                PH_MEAS: begin
                    if (i_echo && !over) begin
                        n_cnt = c_inc;
                    end else begin
                        n_phase = PH_IDLE;
                        n_cnt   = '0;
                    end
                end
                default: begin
                    n_phase = PH_IDLE;
                    n_cnt   = '0;
                end
            endcase
        end
    end

    always_comb begin
        n_step = '0;
        case (r_phase)
            PH_IDLE: n_step.trig = i_start;
            PH_TRIG: n_step.trig = 1'b1;
            PH_WAIT: begin
                if (!i_echo && over) begin
                    n_step.done   = 1'b1;
                    n_step.status = ST_NO_RISE;
                end
            end
            PH_MEAS: begin
                if (i_echo && over) begin
                    n_step.done   = 1'b1;
                    n_step.status = ST_NO_FALL;
                end else if (!i_echo) begin
                    n_step.done     = 1'b1;
                    n_step.meas_end = 1'b1;
                    n_step.width    = r_cnt[WIDTH_W-1:0];
                end
            end
            default: n_step = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_IDLE;
            r_cnt    <= '0;
            r_s1_vld <= 1'b0;
        end else begin
            r_phase <= n_phase;
            r_cnt   <= n_cnt;
            if (i_acc) begin
                r_s1_vld <= 1'b1;
            end else if (i_take) begin
                r_s1_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_acc) begin
            r_s1 <= n_step;
        end
    end

    assign o_ready  = !r_s1_vld || i_take;
    assign o_s1_vld = r_s1_vld;
    assign o_s1     = r_s1;

    a_start_leaves_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_acc && r_phase == PH_IDLE && i_start |=> r_phase == PH_TRIG || r_phase == PH_WAIT)
        else $error("start in idle did not begin a measurement");

    a_trig_not_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_vld |-> !(r_s1.trig && r_s1.done))
        else $error("trigger and finish on the same item");

    a_s1_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_vld && !i_take && !i_acc |=> r_s1_vld && $stable(r_s1))
        else $error("stalled step record changed");

endmodule

// ===== src/uer_dist.sv =====
// uer_dist: range check and distance conversion into the result register.
// Divide by 58 done as reciprocal multiply. Depends on uer_pkg.
`timescale 1ns / 1ps

module uer_dist #(
    parameter int FRAC_BITS = 4
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  uer_pkg::t_cfg  i_cfg,
    input  logic           i_s1_vld,
    input  uer_pkg::t_step i_s1,
    input  logic           i_m_ready,
    output logic           o_take,
    output logic           o_vld,
    output uer_pkg::t_res  o_res
);
    import uer_pkg::*;

    localparam int NUM_W   = WIDTH_W + FRAC_BITS;
    localparam int SHIFT   = NUM_W + 6;
    localparam int RECIP_W = NUM_W + 1;
    localparam int PROD_W  = NUM_W + RECIP_W;
    localparam int QW      = PROD_W - SHIFT;
    localparam int QX_W    = (QW > DIST_W) ? QW : DIST_W;
    localparam logic [63:0] RECIP64 =
        ((64'd1 << SHIFT) + 64'(US_PER_CM) - 64'd1) / 64'(US_PER_CM);
    localparam logic [RECIP_W-1:0] RECIP = RECIP64[RECIP_W-1:0];

    logic               r_vld;
    t_res               r_res, n_res;
    logic               take;
    logic [WIDTH_W-1:0] min_us, max_us;
    logic [NUM_W-1:0]   num;
    logic [PROD_W-1:0]  prod;
    logic [QX_W-1:0]    qx;
    logic [DIST_W-1:0]  dist_sat;

    assign take   = i_s1_vld && (!r_vld || i_m_ready);
    assign min_us = WIDTH_W'(i_cfg.min_cm) * WIDTH_W'(US_PER_CM);
    assign max_us = WIDTH_W'(i_cfg.max_cm) * WIDTH_W'(US_PER_CM);
    assign num    = NUM_W'(i_s1.width) << FRAC_BITS;
    assign prod   = PROD_W'(num) * PROD_W'(RECIP);
    assign qx     = QX_W'(prod[PROD_W-1:SHIFT]);
    assign dist_sat = (qx > QX_W'(DIST_MAX)) ? DIST_MAX : qx[DIST_W-1:0];

    always_comb begin
        n_res.trig    = i_s1.trig;
        n_res.done    = i_s1.done;
        n_res.status  = i_s1.status;
        n_res.dist_q4 = '0;
        if (i_s1.meas_end) begin
            if (i_s1.width < min_us || i_s1.width > max_us) begin
                n_res.status = ST_RANGE;
            end else begin
                n_res.status  = ST_OK;
                n_res.dist_q4 = dist_sat;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (take) begin
            r_vld <= 1'b1;
        end else if (i_m_ready) begin
            r_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_res <= n_res;
        end
    end

    assign o_take = take;
    assign o_vld  = r_vld;
    assign o_res  = r_res;

    a_load_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        take |=> r_vld)
        else $error("loaded result not marked valid");

    a_idle_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld && !r_res.done |-> r_res.status == ST_OK && r_res.dist_q4 == '0)
        else $error("status or distance set without a finished measurement");

    a_fail_no_dist: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld && r_res.status != ST_OK |-> r_res.dist_q4 == '0 && r_res.done)
        else $error("failed measurement carries a distance");

endmodule

// ===== src/ultrasonic_echo_ranger.sv =====
// Echo-pulse range meter, one item per microsecond tick, one result per item.
// Path: an accepted item passes the sequencer step register, then the result
// register holding the reciprocal-multiply distance, whose output is the result.
// Throughput: 1 item per cycle; input stalls only when both stages are full.
// Reset (i_rst_n low, synchronous): idle, count zero, pipeline empty, registers
// at defaults 25000 / 10 / 2 / 400. Depends on uer_pkg, uer_ctrl, uer_dist.
`timescale 1ns / 1ps

module ultrasonic_echo_ranger #(
    parameter int FRAC_BITS = 4
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       s_axis_tvalid,
    output logic                       s_axis_tready,
    input  logic [uer_pkg::IN_W-1:0]   s_axis_tdata,  // [0] start_req, [1] echo
    output logic                       m_axis_tvalid,
    input  logic                       m_axis_tready,
    // [0] trig, [1] done_res, [3:2] status, [17:4] distance_q4
    output logic [uer_pkg::OUT_W-1:0]  m_axis_tdata,
    input  logic                       i_cfg_we,
    input  logic [1:0]                 i_cfg_addr,
    input  logic [uer_pkg::CFG_W-1:0]  i_cfg_wdata
);
    import uer_pkg::*;

    t_cfg  r_cfg;
    logic  acc, take, s1_vld, ready;
    t_step s1;
    t_res  res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.timeout <= TIMEOUT_RST;
            r_cfg.trigger <= TRIGGER_RST;
            r_cfg.min_cm  <= MIN_CM_RST;
            r_cfg.max_cm  <= MAX_CM_RST;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_addr))
                CFG_TIMEOUT: r_cfg.timeout <= i_cfg_wdata;
                CFG_TRIGGER: r_cfg.trigger <= i_cfg_wdata[TRIG_W-1:0];
                CFG_MIN_CM:  r_cfg.min_cm  <= i_cfg_wdata[CM_W-1:0];
                CFG_MAX_CM:  r_cfg.max_cm  <= i_cfg_wdata[CM_W-1:0];
                default:     r_cfg <= r_cfg;
            endcase
        end
    end

    assign s_axis_tready = ready;
    assign acc           = s_axis_tvalid && ready;

    uer_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (r_cfg),
        .i_acc    (acc),
        .i_start  (s_axis_tdata[0]),
        .i_echo   (s_axis_tdata[1]),
        .i_take   (take),
        .o_ready  (ready),
        .o_s1_vld (s1_vld),
        .o_s1     (s1)
    );

    uer_dist #(
        .FRAC_BITS (FRAC_BITS)
    ) u_dist (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (r_cfg),
        .i_s1_vld  (s1_vld),
        .i_s1      (s1),
        .i_m_ready (m_axis_tready),
        .o_take    (take),
        .o_vld     (m_axis_tvalid),
        .o_res     (res)
    );

    assign m_axis_tdata = {(OUT_W - DIST_W - 4)'(0), res.dist_q4, res.status, res.done, res.trig};

endmodule

// ===== test/tb_top.sv =====
// tb_top: self-checking bench for ultrasonic_echo_ranger. A tick-level predictor
// tracks phase, tick count and registers and queues the reading due for each tick.
// Depends on uer_pkg and the ultrasonic_echo_ranger RTL.
`timescale 1ns / 1ps

module tb_top;
    import uer_pkg::*;

    localparam int FRAC_BITS = 4;
    localparam int SETTLE_CYCLES = 8;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [IN_W-1:0] s_tdata = '0;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [OUT_W-1:0] m_tdata;
    logic cfg_we = 1'b0;
    t_cfg_idx cfg_addr = CFG_TIMEOUT;
    logic [CFG_W-1:0] cfg_wdata = '0;

    // predictor state and register shadow
    t_phase pr_phase = PH_IDLE;
    logic [CNT_W-1:0] pr_count = '0;
    logic [WIDTH_W-1:0] cfg_timeout = TIMEOUT_RST;
    logic [TRIG_W-1:0] cfg_trigger = TRIGGER_RST;
    logic [CM_W-1:0] cfg_min_cm = MIN_CM_RST;
    logic [CM_W-1:0] cfg_max_cm = MAX_CM_RST;

    t_res due_readings[$];
    int ticks_sent = 0;
    int error_count = 0;
    int send_idle_pct = 0;
    int sink_stall_pct = 0;
    int hold_left = 0;

    ultrasonic_echo_ranger #(
        .FRAC_BITS(FRAC_BITS)
    ) u_top (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .s_axis_tvalid(s_tvalid),
        .s_axis_tready(s_tready),
        .s_axis_tdata(s_tdata),
        .m_axis_tvalid(m_tvalid),
        .m_axis_tready(m_tready),
        .m_axis_tdata(m_tdata),
        .i_cfg_we(cfg_we),
        .i_cfg_addr(cfg_addr),
        .i_cfg_wdata(cfg_wdata)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // one tick of the ranger: advance state, return the reading for this tick
    function automatic t_res ranging_step(input logic start, input logic echo);
        t_res r;
        int trig_len;
        int width;
        r = '0;
        r.status = ST_OK;
        trig_len = (cfg_trigger == 0) ? 1 : int'(cfg_trigger);
        case (pr_phase)
            PH_IDLE: begin
                if (start) begin
                    pr_phase = PH_TRIG;
                    pr_count = CNT_W'(1);
                    r.trig = 1'b1;
                end
            end
            PH_TRIG: begin
                pr_count = pr_count + 1'b1;
                r.trig = 1'b1;
            end
            PH_WAIT: begin
                if (echo) begin
                    pr_phase = PH_MEAS;
                    pr_count = CNT_W'(1);
                end else begin
                    pr_count = pr_count + 1'b1;
                    if (pr_count > cfg_timeout) begin
                        pr_phase = PH_IDLE;
                        pr_count = '0;
                        r.done = 1'b1;
                        r.status = ST_NO_RISE;
                    end
                end
            end
            default: begin
                if (echo) begin
                    pr_count = pr_count + 1'b1;
                    if (pr_count > cfg_timeout) begin
                        pr_phase = PH_IDLE;
                        pr_count = '0;
                        r.done = 1'b1;
                        r.status = ST_NO_FALL;
                    end
                end else begin
                    width = int'(pr_count);
                    pr_phase = PH_IDLE;
                    pr_count = '0;
                    r.done = 1'b1;
                    if (width < int'(cfg_min_cm) * US_PER_CM ||
                        width > int'(cfg_max_cm) * US_PER_CM) begin
                        r.status = ST_RANGE;
                    end else if (((width << FRAC_BITS) / US_PER_CM) > int'(DIST_MAX)) begin
                        r.dist_q4 = DIST_MAX;
                    end else begin
                        r.dist_q4 = DIST_W'((width << FRAC_BITS) / US_PER_CM);
                    end
                end
            end
        endcase
        if (pr_phase == PH_TRIG && pr_count >= trig_len) begin
            pr_phase = PH_WAIT;
            pr_count = '0;
        end
        return r;
    endfunction

    // result side: random stalls, or a counted hold-off when requested
    always @(negedge i_clk) begin
        if (hold_left > 0) begin
            m_tready <= 1'b0;
            hold_left--;
        end else begin
            m_tready <= ($urandom_range(99) >= sink_stall_pct);
        end
    end

    always @(posedge i_clk) begin : check_readings
        t_res got;
        t_res want;
        if (i_rst_n && m_tvalid && m_tready) begin
            got.trig = m_tdata[0];
            got.done = m_tdata[1];
            got.status = t_status'(m_tdata[3:2]);
            got.dist_q4 = m_tdata[17:4];
            if (due_readings.size() == 0) begin
                $error("reading arrived with none due");
                error_count++;
            end else begin
                want = due_readings.pop_front();
                if (got.trig !== want.trig) begin
                    $error("trig: expected %0d, actual %0d", want.trig, got.trig);
                    error_count++;
                end
                if (got.done !== want.done) begin
                    $error("done_res: expected %0d, actual %0d", want.done, got.done);
                    error_count++;
                end
                if (got.status !== want.status) begin
                    $error("status: expected %0d, actual %0d", want.status, got.status);
                    error_count++;
                end
                if (got.dist_q4 !== want.dist_q4) begin
                    $error("distance_q4: expected %0d, actual %0d", want.dist_q4,
                           got.dist_q4);
                    error_count++;
                end
            end
        end
    end

    // called at a falling edge, returns at a falling edge with valid still high
    task automatic send_tick(input logic start, input logic echo);
        int gap;
        gap = 0;
        while (gap < 40 && $urandom_range(99) < send_idle_pct) gap++;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {{(IN_W-2){1'b0}}, echo, start};
        do @(posedge i_clk); while (!s_tready);
        due_readings.push_back(ranging_step(start, echo));
        ticks_sent++;
        @(negedge i_clk);
    endtask

    task automatic settle();
        s_tvalid <= 1'b0;
        while (due_readings.size() != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic apply_settings(input logic [WIDTH_W-1:0] timeout,
                                  input logic [TRIG_W-1:0] trigger,
                                  input logic [CM_W-1:0] min_cm,
                                  input logic [CM_W-1:0] max_cm);
        logic [CFG_W-1:0] vals [4];
        settle();
        vals = '{CFG_W'(timeout), CFG_W'(trigger), CFG_W'(min_cm), CFG_W'(max_cm)};
        for (int k = 0; k < 4; k++) begin
            cfg_we <= 1'b1;
            cfg_addr <= t_cfg_idx'(k);
            cfg_wdata <= vals[k];
            @(negedge i_clk);
        end
        cfg_we <= 1'b0;
        cfg_timeout = timeout;
        cfg_trigger = trigger;
        cfg_min_cm = min_cm;
        cfg_max_cm = max_cm;
    endtask

    // start, trigger ticks, low wait, high pulse, then the falling tick
    task automatic send_ranging(input int wait_len, input int high_len, input logic end_start);
        int trig_len;
        trig_len = (cfg_trigger == 0) ? 1 : int'(cfg_trigger);
        send_tick(1'b1, 1'($urandom_range(1)));
        repeat (trig_len - 1) send_tick(1'($urandom_range(1)), 1'($urandom_range(1)));
        repeat (wait_len) send_tick(1'($urandom_range(1)), 1'b0);
        repeat (high_len) send_tick(1'($urandom_range(1)), 1'b1);
        send_tick(end_start, 1'b0);
    endtask

    task automatic test_reset_defaults();
        send_tick(1'b0, 1'b1);
        send_ranging(2, 3, 1'b0);
    endtask

    task automatic test_ok_and_busy_start();
        apply_settings(16'd3, 8'd0, 10'd0, 10'd1);
        send_ranging(1, 2, 1'b1);
        send_ranging(0, 3, 1'b0);
    endtask

    task automatic test_no_rise();
        send_ranging(4, 0, 1'b0);
    endtask

    task automatic test_no_fall();
        send_ranging(0, 4, 1'b0);
    endtask

    task automatic test_min_above_max();
        apply_settings(16'd3, 8'd1, 10'd1, 10'd0);
        send_ranging(0, 2, 1'b0);
    endtask

    task automatic test_backpressure();
        apply_settings(16'd40, 8'd2, 10'd0, 10'd1);
        send_idle_pct = 0;
        sink_stall_pct = 0;
        hold_left = 100;
        send_ranging(3, 30, 1'b0);
    endtask

    task automatic test_random_traffic(input int mode, input int send_pct, input int sink_pct);
        int goal;
        int hl;
        int wl;
        int lim;
        send_idle_pct = send_pct;
        sink_stall_pct = sink_pct;
        for (int sb = 0; sb < 3; sb++) begin
            case (mode * 3 + sb)
                0: apply_settings(16'hFFFF, 8'd255, 10'd0, 10'd1023);
                4: apply_settings(16'd1, 8'd1, 10'd1023, 10'd0);
                8: apply_settings(16'd2, 8'd0, 10'd0, 10'd1023);
                default: apply_settings(WIDTH_W'($urandom_range(1, 200)),
                                        TRIG_W'($urandom_range(0, 6)),
                                        CM_W'($urandom_range(0, 3)),
                                        CM_W'($urandom_range(0, 4)));
            endcase
            lim = (cfg_timeout > 300) ? 300 : int'(cfg_timeout);
            goal = ticks_sent + 10;
            while (ticks_sent < goal) begin
                if ($urandom_range(6) == 0) begin
                    repeat ($urandom_range(1, 8))
                        send_tick(1'($urandom_range(1)), 1'($urandom_range(1)));
                end else begin
                    // pulse widths cluster on the range and timeout edges
                    case ($urandom_range(6))
                        0: hl = int'(cfg_min_cm) * US_PER_CM - 1;
                        1: hl = int'(cfg_min_cm) * US_PER_CM;
                        2: hl = int'(cfg_max_cm) * US_PER_CM;
                        3: hl = int'(cfg_max_cm) * US_PER_CM + 1;
                        4: hl = int'(cfg_timeout);
                        5: hl = int'(cfg_timeout) + 1;
                        default: hl = $urandom_range(1, lim + 1);
                    endcase
                    if (hl < 0 || hl > 300) hl = $urandom_range(1, lim + 1);
                    if ($urandom_range(9) == 0 && cfg_timeout < 300)
                        wl = int'(cfg_timeout) + $urandom_range(1);
                    else
                        wl = $urandom_range(0, 12);
                    send_ranging(wl, hl, 1'($urandom_range(1)));
                end
            end
        end
    endtask

    initial begin
        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        test_reset_defaults();
        test_ok_and_busy_start();
        test_no_rise();
        test_no_fall();
        test_min_above_max();
        test_backpressure();
        test_random_traffic(0, 0, 0);
        test_random_traffic(1, 75, 0);
        test_random_traffic(2, 0, 75);
        test_random_traffic(3, 25, 25);
        settle();
        if (error_count == 0 && due_readings.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

    initial begin
        #3000000;
        $display("simulation failed");
        $finish;
    end

endmodule
